// File: rtl/mbps_pkg.sv
// Shared constants and types for the masked byte pattern search block.
package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;
    localparam int SIG_REG_BYTES = 16;
    localparam int RESULT_OFFSET_BITS = 32;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_INDEX_BITS = 2;
    localparam int LEN_BITS = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CARE_MASK = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 2'd3;

    typedef logic [MAX_PATTERN-1:0][7:0] window_t;
    typedef logic [OFFSET_BITS-1:0] count_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] pattern_low;
        logic [CFG_DATA_BITS-1:0] pattern_high;
        logic [SIG_REG_BYTES-1:0] care_mask;
        logic [LEN_BITS-1:0]      pattern_length;
    } config_t;

    typedef struct packed {
        logic                          found;
        logic [RESULT_OFFSET_BITS-1:0] match_offset;
    } result_t;

endpackage

// File: rtl/mbps_match.sv
// Parallel masked compare of the signature against every candidate window length.
module mbps_match
(
    input  mbps_pkg::config_t cfg,
    input  mbps_pkg::window_t window,
    input  mbps_pkg::count_t  count,
    output logic              hit
);

    localparam int SIG_BITS = 8 * mbps_pkg::MAX_PATTERN;

    logic [SIG_BITS+2*mbps_pkg::CFG_DATA_BITS-1:0] sig_ext;
    logic [mbps_pkg::MAX_PATTERN+mbps_pkg::SIG_REG_BYTES-1:0] care_ext;
    logic [mbps_pkg::MAX_PATTERN:0] len_match;
    logic sel_match;
    logic len_ok;

    assign sig_ext = {SIG_BITS'(0), cfg.pattern_high, cfg.pattern_low};
    assign care_ext = {mbps_pkg::MAX_PATTERN'(0), cfg.care_mask};

    // len_match[L]: a window of length L ending in the newest byte matches
    always_comb
    begin
        len_match = '0;
        for (int l = 1; l <= mbps_pkg::MAX_PATTERN; l++)
        begin
            len_match[l] = 1'b1;
            for (int j = 0; j < l; j++)
            begin
                if (care_ext[j] && (sig_ext[8*j +: 8] != window[l-1-j]))
                begin
                    len_match[l] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        sel_match = 1'b0;
        for (int l = 1; l <= mbps_pkg::MAX_PATTERN; l++)
        begin
            if (cfg.pattern_length == mbps_pkg::LEN_BITS'(l))
            begin
                sel_match = len_match[l];
            end
        end
    end

    assign len_ok = (cfg.pattern_length != '0) &&
                    ({mbps_pkg::OFFSET_BITS'(0), cfg.pattern_length} <=
                     (mbps_pkg::OFFSET_BITS + mbps_pkg::LEN_BITS)'(mbps_pkg::MAX_PATTERN)) &&
                    (count >= mbps_pkg::OFFSET_BITS'(cfg.pattern_length));

    assign hit = len_ok && sel_match;

endmodule

// File: rtl/mbps_out.sv
// Result holding register on the master side of the stream.
module mbps_out
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mbps_pkg::result_t result,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,  // match_offset[31:0]
    output logic              m_tuser   // found
);

    logic              valid_reg;
    logic              valid_next;
    mbps_pkg::result_t result_reg;

    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = result_reg.match_offset;
    assign m_tuser = result_reg.found;

endmodule

// File: rtl/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search: region state, configuration and result path.
//
// channel  dir  signals                       request
// s_*      in   tdata[7:0]=data_byte, tlast   one region byte (tlast = region_end)
// m_*      out  tdata[31:0]=offset, tuser     one search result (tuser = found)
// cfg_*    in   cfg_we, cfg_index, cfg_data   register write
//
// One byte per cycle while s_tready is high; a result is registered in the cycle after its byte.
// The compare and region counters sit between input and result register.
// s_tready drops only while a result is held and m_tready is low.
// Reset clears window, byte count, report flag, configuration and output valid; result data is not reset.
module masked_byte_pattern_search
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // match_offset[31:0]
    output logic        m_tuser,   // found
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    mbps_pkg::config_t cfg_reg;
    mbps_pkg::window_t window_reg;
    mbps_pkg::window_t window_new;
    mbps_pkg::count_t  count_reg;
    mbps_pkg::count_t  count_new;
    mbps_pkg::count_t  offset_full;
    logic              reported_reg;
    logic              hit;
    logic              accept;
    logic              emit;
    logic              can_load;
    mbps_pkg::result_t result;
    logic [mbps_pkg::OFFSET_BITS+mbps_pkg::RESULT_OFFSET_BITS-1:0] offset_ext;

    assign s_tready = can_load;
    assign accept = s_tvalid && can_load;

    assign window_new = {window_reg[mbps_pkg::MAX_PATTERN-2:0], s_tdata};
    assign count_new = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    mbps_match u_match
    (
        .cfg    (cfg_reg),
        .window (window_new),
        .count  (count_new),
        .hit    (hit)
    );

    assign offset_full = count_new - mbps_pkg::OFFSET_BITS'(cfg_reg.pattern_length);
    assign offset_ext = {mbps_pkg::RESULT_OFFSET_BITS'(0), offset_full};

    assign emit = !reported_reg && (hit || s_tlast);
    assign result.found = hit;
    assign result.match_offset = hit ? offset_ext[mbps_pkg::RESULT_OFFSET_BITS-1:0] : '0;

    mbps_out u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && emit),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbps_pkg::REG_PATTERN_LOW:    cfg_reg.pattern_low <= cfg_data;
                mbps_pkg::REG_PATTERN_HIGH:   cfg_reg.pattern_high <= cfg_data;
                mbps_pkg::REG_CARE_MASK:
                    cfg_reg.care_mask <= cfg_data[mbps_pkg::SIG_REG_BYTES-1:0];
                mbps_pkg::REG_PATTERN_LENGTH:
                    cfg_reg.pattern_length <= cfg_data[mbps_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                window_reg   <= '0;
                count_reg    <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                window_reg   <= window_new;
                count_reg    <= count_new;
                reported_reg <= reported_reg || hit;
            end
        end
    end

endmodule
